FILE: src/hpq_pkg.sv
// Package for the binary heap priority queue: item field widths,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

  localparam int unsigned URG_W    = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: src/hpq_ifs.sv
// Valid/ready channel interfaces for heap operations and their results.
// Depends on hpq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hpq_in_if import hpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [URG_W-1:0] urgency;
  logic [TAG_W-1:0] tag;

  modport source (output valid, mode, urgency, tag, input ready);
  modport sink   (input valid, mode, urgency, tag, output ready);
endinterface

interface hpq_out_if import hpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [URG_W-1:0]    top_urgency;
  logic [TAG_W-1:0]    top_tag;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, top_urgency, top_tag, occupancy, input ready);
  modport sink   (input valid, status, top_urgency, top_tag, occupancy, output ready);
endinterface

`default_nettype wire

FILE: src/binary_heap_priority_queue_unit.sv
// Top level of the binary heap priority queue with aging: sequencer,
// entry RAM and shared key unit. Depends on hpq_pkg, hpq_ifs, hpq_ram,
// hpq_key_unit.
//
//   channel  | dir | handshake          | payload
//   in_if    | in  | valid/ready        | mode, urgency, tag
//   out_if   | out | valid/ready        | status, top_urgency, top_tag, occupancy
//   cfg      | in  | cfg_we_i, no wait  | cfg_wdata_i = order_min
//
// A push that is taken, or a pop that leaves entries behind, rebuilds the whole heap
// through the single RAM read port, and such a pop then ages every entry left.
// Refused pushes and empty pops skip the rebuild and go straight to the result.
// The result register holds its item until taken; the next item is accepted
// as soon as the sequencer is idle, and a finished item waits for the result
// register to free. Reset empties the heap; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue_unit import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       cfg_we_i,
  input  wire       cfg_wdata_i,
  hpq_in_if.sink    in_if,
  hpq_out_if.source out_if
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = AW + 1;
  localparam int unsigned IW    = CNT_W + 1;
  localparam int unsigned EW    = KEY_BITS + TAG_BITS;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_POP_ROOT  = 4'd1;
  localparam logic [3:0] ST_POP_LAST  = 4'd2;
  localparam logic [3:0] ST_REB_INIT  = 4'd3;
  localparam logic [3:0] ST_SIFT_RD   = 4'd4;
  localparam logic [3:0] ST_SIFT_CUR  = 4'd5;
  localparam logic [3:0] ST_SIFT_L    = 4'd6;
  localparam logic [3:0] ST_SIFT_R    = 4'd7;
  localparam logic [3:0] ST_SIFT_SWAP = 4'd8;
  localparam logic [3:0] ST_SIFT_WB   = 4'd9;
  localparam logic [3:0] ST_SIFT_END  = 4'd10;
  localparam logic [3:0] ST_AGE_RD    = 4'd11;
  localparam logic [3:0] ST_AGE_WR    = 4'd12;
  localparam logic [3:0] ST_DONE      = 4'd13;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                order_min_q;
  logic [AW-1:0]       outer_q, outer_d;
  logic [AW-1:0]       node_q, node_d;
  logic [AW-1:0]       best_q, best_d;
  logic [KEY_BITS-1:0] best_key_q, best_key_d;
  logic [TAG_BITS-1:0] best_tag_q, best_tag_d;
  logic [KEY_BITS-1:0] cur_key_q, cur_key_d;
  logic [TAG_BITS-1:0] cur_tag_q, cur_tag_d;
  logic [KEY_BITS-1:0] top_key_q, top_key_d;
  logic [TAG_BITS-1:0] top_tag_q, top_tag_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                is_pop_q, is_pop_d;

  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [URG_W-1:0]    out_urg_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic [OCC_W-1:0]    out_occ_q;
  logic                out_load;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;

  logic                outranks;
  logic [KEY_BITS-1:0] aged_key;

  logic                accept;
  logic                full;
  logic [CNT_W-1:0]    cnt_m1;
  logic [IW-1:0]       left_w;
  logic [IW-1:0]       right_w;
  logic                left_ok;
  logic                right_ok;
  logic [KEY_BITS+URG_W-1:0] key_in_ext;
  logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
  logic [KEY_BITS+URG_W-1:0] key_out_ext;
  logic [TAG_BITS+TAG_W-1:0] tag_out_ext;
  logic [CNT_W+OCC_W-1:0]    occ_ext;

  hpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[EW-1:TAG_BITS];
  assign rd_tag = ram_rdata[TAG_BITS-1:0];

  hpq_key_unit #(
    .KEY_BITS (KEY_BITS)
  ) u_key_unit (
    .order_min_i (order_min_q),
    .a_i         (rd_key),
    .b_i         (best_key_q),
    .outranks_o  (outranks),
    .aged_o      (aged_key)
  );

  assign accept     = in_if.valid & in_if.ready;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign cnt_m1     = count_q - 1'b1;
  assign left_w     = IW'({node_q, 1'b1});
  assign right_w    = left_w + 1'b1;
  assign left_ok    = (left_w < IW'(count_q));
  assign right_ok   = (right_w < IW'(count_q));
  assign key_in_ext = {{KEY_BITS{1'b0}}, in_if.urgency};
  assign tag_in_ext = {{TAG_BITS{1'b0}}, in_if.tag};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    outer_d    = outer_q;
    node_d     = node_q;
    best_d     = best_q;
    best_key_d = best_key_q;
    best_tag_d = best_tag_q;
    cur_key_d  = cur_key_q;
    cur_tag_d  = cur_tag_q;
    top_key_d  = top_key_q;
    top_tag_d  = top_tag_q;
    status_d   = status_q;
    is_pop_d   = is_pop_q;
    ram_we     = 1'b0;
    ram_waddr  = node_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = node_q;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          top_key_d = '0;
          top_tag_d = '0;
          status_d  = STATUS_OK;
          is_pop_d  = (in_if.mode == MODE_POP);
          if (in_if.mode == MODE_PUSH) begin
            if (full) begin
              status_d = STATUS_FULL;
              state_d  = ST_DONE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = {key_in_ext[KEY_BITS-1:0], tag_in_ext[TAG_BITS-1:0]};
              count_d   = count_q + 1'b1;
              state_d   = ST_REB_INIT;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_DONE;
            end else begin
              ram_raddr = '0;
              state_d   = ST_POP_ROOT;
            end
          end
        end
      end
      ST_POP_ROOT: begin
        top_key_d = rd_key;
        top_tag_d = rd_tag;
        if (count_q == CNT_W'(1)) begin
          count_d = '0;
          state_d = ST_DONE;
        end else begin
          ram_raddr = cnt_m1[AW-1:0];
          state_d   = ST_POP_LAST;
        end
      end
      ST_POP_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        count_d   = cnt_m1;
        state_d   = ST_REB_INIT;
      end
      ST_REB_INIT: begin
        outer_d = cnt_m1[AW:1];
        node_d  = cnt_m1[AW:1];
        state_d = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        ram_raddr = node_q;
        state_d   = ST_SIFT_CUR;
      end
      ST_SIFT_CUR: begin
        cur_key_d  = rd_key;
        cur_tag_d  = rd_tag;
        best_key_d = rd_key;
        best_tag_d = rd_tag;
        best_d     = node_q;
        if (left_ok) begin
          ram_raddr = left_w[AW-1:0];
          state_d   = ST_SIFT_L;
        end else begin
          state_d = ST_SIFT_END;
        end
      end
      ST_SIFT_L: begin
        if (outranks) begin
          best_d     = left_w[AW-1:0];
          best_key_d = rd_key;
          best_tag_d = rd_tag;
        end
        if (right_ok) begin
          ram_raddr = right_w[AW-1:0];
          state_d   = ST_SIFT_R;
        end else begin
          state_d = ST_SIFT_SWAP;
        end
      end
      ST_SIFT_R: begin
        if (outranks) begin
          best_d     = right_w[AW-1:0];
          best_key_d = rd_key;
          best_tag_d = rd_tag;
        end
        state_d = ST_SIFT_SWAP;
      end
      ST_SIFT_SWAP: begin
        if (best_q == node_q) begin
          state_d = ST_SIFT_END;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = node_q;
          ram_wdata = {best_key_q, best_tag_q};
          state_d   = ST_SIFT_WB;
        end
      end
      ST_SIFT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = best_q;
        ram_wdata = {cur_key_q, cur_tag_q};
        node_d    = best_q;
        state_d   = ST_SIFT_RD;
      end
      ST_SIFT_END: begin
        if (outer_q == '0) begin
          node_d  = '0;
          state_d = is_pop_q ? ST_AGE_RD : ST_DONE;
        end else begin
          outer_d = outer_q - 1'b1;
          node_d  = outer_q - 1'b1;
          state_d = ST_SIFT_RD;
        end
      end
      ST_AGE_RD: begin
        ram_raddr = node_q;
        state_d   = ST_AGE_WR;
      end
      ST_AGE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = {aged_key, rd_tag};
        if (CNT_W'(node_q) == cnt_m1) begin
          state_d = ST_DONE;
        end else begin
          node_d  = node_q + 1'b1;
          state_d = ST_AGE_RD;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      order_min_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        order_min_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign key_out_ext = {{URG_W{1'b0}}, top_key_q};
  assign tag_out_ext = {{TAG_W{1'b0}}, top_tag_q};
  assign occ_ext     = {{OCC_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    outer_q    <= outer_d;
    node_q     <= node_d;
    best_q     <= best_d;
    best_key_q <= best_key_d;
    best_tag_q <= best_tag_d;
    cur_key_q  <= cur_key_d;
    cur_tag_q  <= cur_tag_d;
    top_key_q  <= top_key_d;
    top_tag_q  <= top_tag_d;
    status_q   <= status_d;
    is_pop_q   <= is_pop_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_urg_q    <= key_out_ext[URG_W-1:0];
      out_tag_q    <= tag_out_ext[TAG_W-1:0];
      out_occ_q    <= occ_ext[OCC_W-1:0];
    end
  end

  assign in_if.ready        = (state_q == ST_IDLE);
  assign out_if.valid       = out_vld_q;
  assign out_if.status      = out_status_q;
  assign out_if.top_urgency = out_urg_q;
  assign out_if.top_tag     = out_tag_q;
  assign out_if.occupancy   = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_push_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.mode == MODE_PUSH && full) |=> $stable(count_q))
    else $error("refused push changed the entry count");

  a_empty_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.mode == MODE_POP && count_q == '0) |=> (state_q == ST_DONE))
    else $error("empty pop did not finish at once");

  a_ram_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CNT_W'(ram_waddr) < count_q || state_q == ST_POP_LAST ||
                (state_q == ST_IDLE && CNT_W'(ram_waddr) == count_q)))
    else $error("RAM write beyond held entries");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |=> (out_vld_q && $stable(out_status_q)))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

FILE: src/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/hpq_key_unit.sv
// Shared key unit: heap-order compare of two keys and the saturating
// aging step of the first key. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hpq_key_unit #(
  parameter int unsigned KEY_BITS = 16
) (
  input  wire                 order_min_i,
  input  wire  [KEY_BITS-1:0] a_i,
  input  wire  [KEY_BITS-1:0] b_i,
  output logic                outranks_o,
  output logic [KEY_BITS-1:0] aged_o
);

  always_comb begin
    if (order_min_i) begin
      outranks_o = (a_i < b_i);
      aged_o     = (a_i != '0) ? a_i - 1'b1 : a_i;
    end else begin
      outranks_o = (a_i > b_i);
      aged_o     = (a_i != '1) ? a_i + 1'b1 : a_i;
    end
  end

endmodule

`default_nettype wire
